FILE: hdl/boid_cohesion_velocity_assert.svh
// Assertion macros for the boid cohesion velocity block.
// Used by the checker module; needs clk_i and rst_ni in the scope of each use.
`ifndef BOID_COHESION_VELOCITY_ASSERT_SVH
`define BOID_COHESION_VELOCITY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCV_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("boid cohesion check failed");

// The consequent must hold in the cycle after the antecedent.
`define BCV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("boid cohesion check failed");

`endif

FILE: hdl/bcv_pkg.sv
// Shared constants, types and the sequencer state encoding for the boid cohesion block.
// No dependencies; imported by every module of the block.
package bcv_pkg;

  // Field widths.
  localparam int POS_W   = 16;
  localparam int COLOR_W = 8;
  localparam int SUM_W   = 27;
  localparam int CNT_W   = 11;
  localparam int VEL_W   = 24;
  localparam int DIST_W  = 33;
  localparam int GAIN_W  = 16;
  localparam int DIFF_W  = POS_W + 1;
  localparam int D2_W    = 2 * DIFF_W;

  // Neighbour count limit, capped so that it fits the count field.
  localparam int MAX_NEIGHBORS = 1024;
  localparam int CNT_FIELD_MAX = (1 << CNT_W) - 1;
  localparam int COUNT_LIMIT   = (MAX_NEIGHBORS > CNT_FIELD_MAX) ? CNT_FIELD_MAX : MAX_NEIGHBORS;

  // Shared multiplier operand and product widths.
  localparam int MUL_A_W = SUM_W + 2;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Divider: dividend width and step counter width.
  localparam int FRAC_W    = 12;
  localparam int DIV_W     = 32;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  // Configuration port.
  localparam int APB_AW = 4;
  localparam int APB_DW = 64;

  typedef enum logic [0:0] {
    REG_NEAR_DIST_SQ = 1'b0,
    REG_GAIN         = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEC,
    ST_SQY,
    ST_CMP,
    ST_FIN,
    ST_FNF,
    ST_FSUB,
    ST_FMG,
    ST_FDIV0,
    ST_FDIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               req_type;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [COLOR_W-1:0] flock_color;
    logic               is_self;
    logic               last;
  } item_t;

  typedef struct packed {
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

FILE: hdl/bcv_mul.sv
// Shared signed multiplier with a registered product.
// Depends on bcv_pkg for operand widths and the request type.
module bcv_mul (
  input  logic                     clk_i,
  input  bcv_pkg::mul_req_t        req_i,
  output logic [bcv_pkg::PROD_W-1:0] prod_o
);
  import bcv_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // One signed product per cycle, registered.
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(req_i.a) * $signed(req_i.b);
  end

  assign prod_o = prod_q;

endmodule

FILE: hdl/bcv_div.sv
// Restoring divider, one quotient bit per cycle, for the mean position division.
// Depends on bcv_pkg for widths and the request and response types.
module bcv_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bcv_pkg::div_req_t req_i,
  output bcv_pkg::div_rsp_t rsp_o
);
  import bcv_pkg::*;

  logic [CNT_W-1:0]     rem_q, rem_d;
  logic [DIV_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     divs_q, divs_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CNT_W:0]       trial;
  logic                 fits;

  // Trial subtraction of the divisor from the shifted remainder.
  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = trial >= {1'b0, divs_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    divs_d = divs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend;
      divs_d = req_i.divisor;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = fits ? CNT_W'(trial - {1'b0, divs_q}) : trial[CNT_W-1:0];
      quo_d = {quo_q[DIV_W-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    divs_q <= divs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: hdl/boid_cohesion_velocity.sv
// Boid cohesion velocity: a sequencer drives one shared multiplier and a bit-serial divider.
// A focal word needs no multiply; a candidate neighbour word takes one multiply per axis for the
// squared distance. A last word then runs the 32-step divider once per axis, or skips it with
// no neighbour counted, and may wait for the output register; one word is in work at a time.
// Reset is asynchronous and active low. It clears focal boid, sums, count and output valid,
// sets the radius to zero and the gain to unity. Depends on bcv_pkg, bcv_mul and bcv_div.
module boid_cohesion_velocity (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         req_type_i,
  input  logic signed [bcv_pkg::POS_W-1:0] pos_x_i,
  input  logic signed [bcv_pkg::POS_W-1:0] pos_y_i,
  input  logic [bcv_pkg::COLOR_W-1:0]  flock_color_i,
  input  logic                         is_self_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [bcv_pkg::VEL_W-1:0] vel_x_o,
  output logic signed [bcv_pkg::VEL_W-1:0] vel_y_o,
  output logic [bcv_pkg::CNT_W-1:0]    neighbor_count_o,
  output logic                         count_saturated_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bcv_pkg::APB_AW-1:0]   paddr,
  input  logic [bcv_pkg::APB_DW-1:0]   pwdata,
  output logic [bcv_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import bcv_pkg::*;

  // Sum plus a position, saturated to the sum range.
  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] s, logic [POS_W-1:0] p);
    logic [SUM_W:0] t;
    t = {s[SUM_W-1], s} + {{(SUM_W + 1 - POS_W){p[POS_W-1]}}, p};
    if (t[SUM_W] != t[SUM_W-1]) begin
      sat_sum = t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_sum = t[SUM_W-1:0];
    end
  endfunction

  // Signed velocity from sign and quotient magnitude, saturated.
  function automatic logic [VEL_W-1:0] sat_vel(logic neg, logic [DIV_W-1:0] q);
    logic big;
    big = |q[DIV_W-1:VEL_W-1];
    if (neg) begin
      sat_vel = big ? {1'b1, {(VEL_W-1){1'b0}}} : VEL_W'(0) - q[VEL_W-1:0];
    end else begin
      sat_vel = big ? {1'b0, {(VEL_W-1){1'b1}}} : q[VEL_W-1:0];
    end
  endfunction

  state_e state_q, state_d;
  item_t  item_q, item_d;

  logic [DIST_W-1:0]  near_q;
  logic [GAIN_W-1:0]  gain_q;
  logic [POS_W-1:0]   focal_x_q, focal_x_d, focal_y_q, focal_y_d;
  logic [COLOR_W-1:0] focal_color_q, focal_color_d;
  logic [SUM_W-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               ovf_q, ovf_d;
  logic               ax_q, ax_d;
  logic               neg_q, neg_d;
  logic [D2_W-1:0]    d2_q, d2_d;
  logic [MUL_A_W-1:0] diff_q, diff_d;
  logic [VEL_W-1:0]   vx_q, vx_d, vy_q, vy_d;

  logic               out_valid_q, out_valid_d;
  logic [VEL_W-1:0]   out_vx_q, out_vx_d, out_vy_q, out_vy_d;
  logic [CNT_W-1:0]   out_cnt_q, out_cnt_d;
  logic               out_sat_q, out_sat_d;

  mul_req_t           mul_req;
  logic [PROD_W-1:0]  prod;
  div_req_t           div_req;
  div_rsp_t           div_rsp;

  logic [DIFF_W-1:0]  dx, dy;
  logic [D2_W-1:0]    d2_sum;
  logic               candidate, hit, full;
  logic [SUM_W-1:0]   sel_sum;
  logic [POS_W-1:0]   sel_focal;
  logic               prod_neg;
  logic [PROD_W-1:0]  mag, rnd;
  logic               cfg_wr;

  bcv_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  bcv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // Configuration port: always ready, one register per 8-byte slot.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    unique case (reg_idx_e'(paddr[3]))
      REG_NEAR_DIST_SQ: prdata = APB_DW'(near_q);
      REG_GAIN:         prdata = {{(APB_DW - GAIN_W){gain_q[GAIN_W-1]}}, gain_q};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q <= '0;
      gain_q <= GAIN_W'(1 << FRAC_W);
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[3]))
        REG_NEAR_DIST_SQ: near_q <= pwdata[DIST_W-1:0];
        REG_GAIN:         gain_q <= pwdata[GAIN_W-1:0];
        default:          ;
      endcase
    end
  end

  // Neighbour test terms.
  assign dx        = {item_q.pos_x[POS_W-1], item_q.pos_x} - {focal_x_q[POS_W-1], focal_x_q};
  assign dy        = {item_q.pos_y[POS_W-1], item_q.pos_y} - {focal_y_q[POS_W-1], focal_y_q};
  assign candidate = !item_q.is_self && (item_q.flock_color == focal_color_q);
  assign d2_sum    = d2_q + prod[D2_W-1:0];
  assign hit       = d2_sum < {{(D2_W - DIST_W){1'b0}}, near_q};
  assign full      = count_q >= CNT_W'(COUNT_LIMIT);

  // Final division terms for the current axis.
  assign sel_sum   = ax_q ? sum_y_q : sum_x_q;
  assign sel_focal = ax_q ? focal_y_q : focal_x_q;
  assign prod_neg  = prod[PROD_W-1];
  assign mag       = prod_neg ? PROD_W'(0) - prod : prod;
  assign rnd       = mag + {{(PROD_W - CNT_W - FRAC_W + 1){1'b0}}, count_q, {(FRAC_W-1){1'b0}}};

  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer: next state, operand selection and register updates.
  always_comb begin
    state_d       = state_q;
    item_d        = item_q;
    focal_x_d     = focal_x_q;
    focal_y_d     = focal_y_q;
    focal_color_d = focal_color_q;
    sum_x_d       = sum_x_q;
    sum_y_d       = sum_y_q;
    count_d       = count_q;
    ovf_d         = ovf_q;
    ax_d          = ax_q;
    neg_d         = neg_q;
    d2_d          = d2_q;
    diff_d        = diff_q;
    vx_d          = vx_q;
    vy_d          = vy_q;
    out_vx_d      = out_vx_q;
    out_vy_d      = out_vy_q;
    out_cnt_d     = out_cnt_q;
    out_sat_d     = out_sat_q;
    out_valid_d   = out_valid_q & ~out_ready_i;
    mul_req       = '0;
    div_req.start    = 1'b0;
    div_req.dividend = rnd[FRAC_W +: DIV_W];
    div_req.divisor  = count_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d.req_type    = req_type_i;
          item_d.pos_x       = pos_x_i;
          item_d.pos_y       = pos_y_i;
          item_d.flock_color = flock_color_i;
          item_d.is_self     = is_self_i;
          item_d.last        = last_i;
          state_d            = ST_DEC;
        end
      end
      ST_DEC: begin
        if (!item_q.req_type) begin
          // Focal word: load the focal boid and start a new group.
          focal_x_d     = item_q.pos_x;
          focal_y_d     = item_q.pos_y;
          focal_color_d = item_q.flock_color;
          sum_x_d       = '0;
          sum_y_d       = '0;
          count_d       = '0;
          ovf_d         = 1'b0;
          state_d       = item_q.last ? ST_FIN : ST_IDLE;
        end else if (candidate) begin
          mul_req.a = {{(MUL_A_W - DIFF_W){dx[DIFF_W-1]}}, dx};
          mul_req.b = dx;
          state_d   = ST_SQY;
        end else begin
          state_d = item_q.last ? ST_FIN : ST_IDLE;
        end
      end
      ST_SQY: begin
        d2_d      = prod[D2_W-1:0];
        mul_req.a = {{(MUL_A_W - DIFF_W){dy[DIFF_W-1]}}, dy};
        mul_req.b = dy;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        // Within the radius: accumulate, or flag once the count is full.
        if (hit) begin
          if (!full) begin
            sum_x_d = sat_sum(sum_x_q, item_q.pos_x);
            sum_y_d = sat_sum(sum_y_q, item_q.pos_y);
            count_d = count_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
        state_d = item_q.last ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        ax_d    = 1'b0;
        state_d = (count_q == '0) ? ST_EMIT : ST_FNF;
      end
      ST_FNF: begin
        mul_req.a = {{(MUL_A_W - CNT_W){1'b0}}, count_q};
        mul_req.b = {sel_focal[POS_W-1], sel_focal};
        state_d   = ST_FSUB;
      end
      ST_FSUB: begin
        diff_d  = {{(MUL_A_W - SUM_W){sel_sum[SUM_W-1]}}, sel_sum} - prod[MUL_A_W-1:0];
        state_d = ST_FMG;
      end
      ST_FMG: begin
        mul_req.a = diff_q;
        mul_req.b = {gain_q[GAIN_W-1], gain_q};
        state_d   = ST_FDIV0;
      end
      ST_FDIV0: begin
        neg_d         = prod_neg;
        div_req.start = 1'b1;
        state_d       = ST_FDIV;
      end
      ST_FDIV: begin
        if (div_rsp.done) begin
          if (!ax_q) begin
            vx_d    = sat_vel(neg_q, div_rsp.quotient);
            ax_d    = 1'b1;
            state_d = ST_FNF;
          end else begin
            vy_d    = sat_vel(neg_q, div_rsp.quotient);
            state_d = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || out_ready_i) begin
          out_vx_d    = (count_q == '0) ? '0 : vx_q;
          out_vy_d    = (count_q == '0) ? '0 : vy_q;
          out_cnt_d   = count_q;
          out_sat_d   = ovf_q;
          out_valid_d = 1'b1;
          sum_x_d     = '0;
          sum_y_d     = '0;
          count_d     = '0;
          ovf_d       = 1'b0;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      focal_x_q     <= '0;
      focal_y_q     <= '0;
      focal_color_q <= '0;
      sum_x_q       <= '0;
      sum_y_q       <= '0;
      count_q       <= '0;
      ovf_q         <= 1'b0;
      ax_q          <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      focal_x_q     <= focal_x_d;
      focal_y_q     <= focal_y_d;
      focal_color_q <= focal_color_d;
      sum_x_q       <= sum_x_d;
      sum_y_q       <= sum_y_d;
      count_q       <= count_d;
      ovf_q         <= ovf_d;
      ax_q          <= ax_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    neg_q     <= neg_d;
    d2_q      <= d2_d;
    diff_q    <= diff_d;
    vx_q      <= vx_d;
    vy_q      <= vy_d;
    out_vx_q  <= out_vx_d;
    out_vy_q  <= out_vy_d;
    out_cnt_q <= out_cnt_d;
    out_sat_q <= out_sat_d;
  end

  assign out_valid_o       = out_valid_q;
  assign vel_x_o           = out_vx_q;
  assign vel_y_o           = out_vy_q;
  assign neighbor_count_o  = out_cnt_q;
  assign count_saturated_o = out_sat_q;

endmodule

FILE: hdl/bcv_checker.sv
// Port-level checks for the boid cohesion block, bound to the top level.
// Depends on bcv_pkg and the macros in boid_cohesion_velocity_assert.svh.
`include "boid_cohesion_velocity_assert.svh"

module bcv_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [bcv_pkg::VEL_W-1:0]    vel_x_o,
  input logic [bcv_pkg::VEL_W-1:0]    vel_y_o,
  input logic [bcv_pkg::CNT_W-1:0]    neighbor_count_o,
  input logic                         count_saturated_o
);
  import bcv_pkg::*;

  // A result word waiting on the output holds until taken.
  `BCV_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(vel_x_o) && $stable(vel_y_o) && $stable(neighbor_count_o))

  // Once a word is accepted, the block is busy and drops its input ready.
  `BCV_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // A saturated count reports exactly the limit.
  `BCV_ASSERT_NOW(a_sat_count, out_valid_o && count_saturated_o, neighbor_count_o == CNT_W'(COUNT_LIMIT))

  // No neighbours counted means zero velocity and no saturation.
  `BCV_ASSERT_NOW(a_empty_zero, out_valid_o && (neighbor_count_o == '0), (vel_x_o == '0) && (vel_y_o == '0) && !count_saturated_o)

endmodule

bind boid_cohesion_velocity bcv_checker u_bcv_checker (.*);

FILE: sim/bcv_cohesion_checker.sv
// Checker for the boid cohesion velocity block: follows register writes and accepted words,
// predicts each cohesion result and compares it with what the block delivers.
// Depends on bcv_pkg for widths, the count limit and the register indexes.
module bcv_cohesion_checker
  import bcv_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     req_type_i,
  input  logic signed [POS_W-1:0]  pos_x_i,
  input  logic signed [POS_W-1:0]  pos_y_i,
  input  logic [COLOR_W-1:0]       flock_color_i,
  input  logic                     is_self_i,
  input  logic                     last_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [VEL_W-1:0]  vel_x_i,
  input  logic signed [VEL_W-1:0]  vel_y_i,
  input  logic [CNT_W-1:0]         neighbor_count_i,
  input  logic                     count_saturated_i,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  input  logic                     pready,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam longint SUM_HI = (64'sd1 <<< (SUM_W - 1)) - 1;
  localparam longint SUM_LO = -(64'sd1 <<< (SUM_W - 1));
  localparam longint VEL_HI = (64'sd1 <<< (VEL_W - 1)) - 1;
  localparam longint VEL_LO = -(64'sd1 <<< (VEL_W - 1));

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [CNT_W-1:0]        count;
    logic                    saturated;
  } pull_t;

  // Results still owed by the block, oldest first.
  pull_t pull_due[$];

  // Shadow of the registers and of the accumulator state.
  logic [DIST_W-1:0]        near_sq;
  logic signed [GAIN_W-1:0] gain_q;
  logic signed [POS_W-1:0]  focal_x;
  logic signed [POS_W-1:0]  focal_y;
  logic [COLOR_W-1:0]       focal_hue;
  longint                   sum_x;
  longint                   sum_y;
  int unsigned              match_n;
  bit                       count_full;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Mean offset from the focal boid times the gain, rounded half away from zero.
  function automatic logic signed [VEL_W-1:0] mean_pull(longint s, longint f, int unsigned n);
    longint num;
    longint unsigned den;
    longint unsigned mag;
    longint unsigned q;
    longint r;
    num = (s - longint'(n) * f) * longint'(gain_q);
    den = longint'(n) * 4096;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = (mag + den / 2) / den;
    if (q > longint'(VEL_HI) + 1) q = longint'(VEL_HI) + 1;
    r = (num < 0) ? -longint'(q) : longint'(q);
    return VEL_W'(clamp(r, VEL_LO, VEL_HI));
  endfunction

  task automatic clear_group();
    sum_x      = 0;
    sum_y      = 0;
    match_n    = 0;
    count_full = 0;
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endtask

  // Fold one accepted word into the state and queue the result it causes.
  task automatic absorb_boid();
    longint dx;
    longint dy;
    longint d2;
    pull_t  res;
    if (!req_type_i) begin
      focal_x   = pos_x_i;
      focal_y   = pos_y_i;
      focal_hue = flock_color_i;
      clear_group();
    end else if (!is_self_i && flock_color_i == focal_hue) begin
      dx = longint'(pos_x_i) - longint'(focal_x);
      dy = longint'(pos_y_i) - longint'(focal_y);
      d2 = dx * dx + dy * dy;
      if (d2 < longint'(near_sq)) begin
        if (match_n < COUNT_LIMIT) begin
          sum_x = clamp(sum_x + longint'(pos_x_i), SUM_LO, SUM_HI);
          sum_y = clamp(sum_y + longint'(pos_y_i), SUM_LO, SUM_HI);
          match_n++;
        end else begin
          count_full = 1;
        end
      end
    end
    if (last_i) begin
      res.vel_x     = '0;
      res.vel_y     = '0;
      res.count     = CNT_W'(match_n);
      res.saturated = count_full;
      if (match_n > 0) begin
        res.vel_x = mean_pull(sum_x, longint'(focal_x), match_n);
        res.vel_y = mean_pull(sum_y, longint'(focal_y), match_n);
      end
      pull_due.push_back(res);
      clear_group();
    end
  endtask

  // Results are compared before the word of the same edge is folded in.
  always @(posedge clk_i or negedge rst_ni) begin
    pull_t due;
    if (!rst_ni) begin
      near_sq      = '0;
      gain_q       = 16'sd4096;
      focal_x      = '0;
      focal_y      = '0;
      focal_hue    = '0;
      clear_group();
      pull_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pull_due.size() == 0) begin
          $error("result delivered with nothing outstanding: vel_x %0d vel_y %0d",
                 vel_x_i, vel_y_i);
          fail_count_o++;
        end else begin
          due = pull_due.pop_front();
          check_field("vel_x", due.vel_x, vel_x_i);
          check_field("vel_y", due.vel_y, vel_y_i);
          check_field("neighbor_count", due.count, neighbor_count_i);
          check_field("count_saturated", due.saturated, count_saturated_i);
        end
      end
      if (psel && penable && pwrite && pready && paddr[2:0] == 3'b000) begin
        case (reg_idx_e'(paddr[3:3]))
          REG_NEAR_DIST_SQ: near_sq = pwdata[DIST_W-1:0];
          REG_GAIN:         gain_q  = pwdata[GAIN_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) absorb_boid();
      pending_o = pull_due.size();
    end
  end

endmodule

FILE: sim/testbench.sv
// Top of the boid cohesion velocity testbench: clock, reset, register writes and boid words,
// with random idling on both channels and a verdict from the checker's failure count.
// Depends on bcv_pkg, boid_cohesion_velocity and bcv_cohesion_checker.
module testbench;
  import bcv_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid;
  logic               in_ready;
  logic               req_type;
  logic [POS_W-1:0]   pos_x;
  logic [POS_W-1:0]   pos_y;
  logic [COLOR_W-1:0] flock_color;
  logic               is_self;
  logic               last;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [VEL_W-1:0]   vel_x;
  logic [VEL_W-1:0]   vel_y;
  logic [CNT_W-1:0]   neighbor_count;
  logic               count_saturated;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;
  int                 fail_count;
  int                 pending;

  // Idling percentages, the long hold-off request and the last focal boid sent.
  int                 src_idle_pct = 0;
  int                 snk_stall_pct = 0;
  bit                 hold_go = 1'b0;
  int                 words_sent = 0;
  logic [POS_W-1:0]   last_fx = '0;
  logic [POS_W-1:0]   last_fy = '0;
  logic [COLOR_W-1:0] last_hue = '0;

  boid_cohesion_velocity dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .req_type_i        (req_type),
    .pos_x_i           (pos_x),
    .pos_y_i           (pos_y),
    .flock_color_i     (flock_color),
    .is_self_i         (is_self),
    .last_i            (last),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .vel_x_o           (vel_x),
    .vel_y_o           (vel_y),
    .neighbor_count_o  (neighbor_count),
    .count_saturated_o (count_saturated),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  bcv_cohesion_checker checker_u (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .req_type_i        (req_type),
    .pos_x_i           (pos_x),
    .pos_y_i           (pos_y),
    .flock_color_i     (flock_color),
    .is_self_i         (is_self),
    .last_i            (last),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .vel_x_i           (vel_x),
    .vel_y_i           (vel_y),
    .neighbor_count_i  (neighbor_count),
    .count_saturated_i (count_saturated),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .pready            (pready),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Free-running clock, period 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result side: random stalls, plus one long hold-off counted here.
  always @(negedge clk_i) begin
    static int  hold_left = 0;
    static bit  hold_taken = 1'b0;
    if (hold_go && !hold_taken) begin
      hold_left  = 400;
      hold_taken = 1'b1;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // Safety net against a hung handshake.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic item_t boid(bit req, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                 logic [COLOR_W-1:0] hue, bit self, bit fin);
    item_t w;
    w.req_type    = req;
    w.pos_x       = x;
    w.pos_y       = y;
    w.flock_color = hue;
    w.is_self     = self;
    w.last        = fin;
    return w;
  endfunction

  // Offer one word after a random gap and hold it until it is taken.
  task automatic push_word(item_t w);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    req_type    = w.req_type;
    pos_x       = w.pos_x;
    pos_y       = w.pos_y;
    flock_color = w.flock_color;
    is_self     = w.is_self;
    last        = w.last;
    in_valid    = 1'b1;
    if (!w.req_type) begin
      last_fx  = w.pos_x;
      last_fy  = w.pos_y;
      last_hue = w.flock_color;
    end
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic apb_write(reg_idx_e idx, logic [APB_DW-1:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Let every owed result arrive, then give a word with no result time to finish.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
  endtask

  task automatic setup_phase(logic [DIST_W-1:0] near, logic [GAIN_W-1:0] g, int src, int snk);
    drain();
    apb_write(REG_NEAR_DIST_SQ, APB_DW'(near));
    apb_write(REG_GAIN, APB_DW'(g));
    src_idle_pct  = src;
    snk_stall_pct = snk;
  endtask

  // One random flock: mostly a focal word and nearby neighbours ending on last,
  // sometimes lone noise, groups without a focal word, or groups left unfinished.
  task automatic random_flock();
    int               pick;
    int               k;
    int               span;
    int               ox;
    int               oy;
    bit               broken;
    logic [COLOR_W-1:0] hue;
    logic [COLOR_W-1:0] c;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      push_word(boid(1'($urandom_range(0, 1)), POS_W'($urandom), POS_W'($urandom),
                     COLOR_W'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1))));
      return;
    end
    k      = $urandom_range(0, 10);
    broken = ($urandom_range(0, 19) == 0);
    if (pick >= 14) begin
      hue = ($urandom_range(0, 9) < 7) ? COLOR_W'($urandom_range(0, 3)) : COLOR_W'($urandom);
      push_word(boid(1'b0, POS_W'($urandom), POS_W'($urandom), hue,
                     1'($urandom_range(0, 1)), (k == 0) && !broken));
    end
    for (int i = 0; i < k; i++) begin
      case ($urandom_range(0, 3))
        0: span = 64;
        1: span = 1024;
        2: span = 8192;
        default: span = 65535;
      endcase
      ox = int'($urandom_range(0, 2 * span)) - span;
      oy = int'($urandom_range(0, 2 * span)) - span;
      c  = ($urandom_range(0, 99) < 85) ? last_hue : COLOR_W'($urandom);
      push_word(boid(1'b1, POS_W'(last_fx + ox), POS_W'(last_fy + oy), c,
                     $urandom_range(0, 99) < 8, (i == k - 1) && !broken));
    end
  endtask

  task automatic random_run(int n);
    int stop_at;
    stop_at = words_sent + n;
    while (words_sent < stop_at) random_flock();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    req_type    = 1'b0;
    pos_x       = '0;
    pos_y       = '0;
    flock_color = '0;
    is_self     = 1'b0;
    last        = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: radius of 1024 in signed Q15.0 position units, unity gain.
    setup_phase(33'd1 << 20, 16'sd4096, 0, 0);
    // Neighbours before any focal load meet the reset focal boid.
    push_word(boid(1'b1, 16, -16, 0, 0, 0));
    push_word(boid(1'b1, -1000, 300, 0, 0, 1));
    // Last on a focal word gives a zero result.
    push_word(boid(1'b0, 100, -50, 3, 0, 1));
    // Kept focal boid starts a new group; colour, self and the radius boundary.
    push_word(boid(1'b1, 100, -50, 3, 0, 0));
    push_word(boid(1'b1, 120, -40, 4, 0, 0));
    push_word(boid(1'b1, 110, -45, 3, 1, 0));
    push_word(boid(1'b1, 1124, -50, 3, 0, 0));
    push_word(boid(1'b1, 1123, -50, 3, 0, 1));
    // A group in which nothing counts.
    push_word(boid(1'b1, 100, -50, 9, 0, 1));

    // Position extremes with the widest radius and both gain extremes.
    setup_phase(33'h1_FFFF_FFFF, 16'sh7FFF, 0, 0);
    push_word(boid(1'b0, 16'h7FFF, 16'h7FFF, 8'hFF, 0, 0));
    push_word(boid(1'b1, 16'h8000, 16'h8000, 8'hFF, 0, 1));
    setup_phase(33'h1_FFFF_FFFF, 16'sh8000, 0, 0);
    push_word(boid(1'b0, 16'h8000, 16'h8000, 0, 0, 0));
    push_word(boid(1'b1, 16'h7FFF, 16'h7FFF, 0, 0, 0));
    push_word(boid(1'b1, 16'h7FFF, 16'h8000, 0, 0, 1));
    push_word(boid(1'b0, 16'h0001, 16'hFFFF, 8'h80, 1, 1));
    // Zero radius: nothing ever counts.
    setup_phase(33'd0, 16'sd4096, 0, 0);
    push_word(boid(1'b0, 0, 0, 0, 0, 0));
    push_word(boid(1'b1, 0, 0, 0, 0, 1));

    // Random phases across register settings and idling patterns.
    setup_phase(33'd1 << 20, 16'sd4096, 0, 0);
    random_run(20);

    setup_phase(33'h1_FFFF_FFFF, 16'sh7FFF, 60, 0);
    // Count full: more qualifying neighbours than the count limit.
    push_word(boid(1'b0, POS_W'($urandom), POS_W'($urandom), 5, 0, 0));
    for (int i = 0; i < COUNT_LIMIT + 6; i++) begin
      push_word(boid(1'b1, POS_W'($urandom), POS_W'($urandom), 5, 0,
                     i == COUNT_LIMIT + 5));
    end
    // Long hold-off on the result side while words keep coming.
    hold_go = 1'b1;
    random_run(20);

    setup_phase(33'd0, 16'sh8000, 0, 60);
    random_run(20);

    setup_phase({1'b0, 32'($urandom_range(1, 1 << 24))}, GAIN_W'($urandom), 38, 38);
    random_run(20);

    setup_phase(33'd1 << 22, 16'sd0, 60, 0);
    random_run(20);

    setup_phase(33'h1_0000_0000, 16'shFFFF, 0, 60);
    random_run(20);

    setup_phase(33'd1 << 18, 16'sd4096, 38, 38);
    random_run(20);

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: boid_cohesion_velocity.f
+incdir+hdl
hdl/bcv_pkg.sv
hdl/bcv_mul.sv
hdl/bcv_div.sv
hdl/boid_cohesion_velocity.sv
hdl/bcv_checker.sv
sim/bcv_cohesion_checker.sv
sim/testbench.sv
